// File: src/ctgs_pkg.sv
// Package for the chunk-grouping task scheduler.
// Holds sizes, status and action codes and the item structs.
// No dependencies.
package ctgs_pkg;

	localparam int MAX_GROUPS  = 16;
	localparam int GROUP_DEPTH = 16;
	localparam int SLOT_W      = $clog2(MAX_GROUPS);
	localparam int POS_W       = $clog2(GROUP_DEPTH);
	localparam int COUNT_W     = $clog2(MAX_GROUPS + 1);
	localparam int FILL_W      = $clog2(GROUP_DEPTH + 1);
	localparam int ADDR_W      = SLOT_W + POS_W;
	localparam int STORE_DEPTH = MAX_GROUPS * GROUP_DEPTH;
	localparam int TAG_W       = 16;
	localparam int KEY_W       = 20;
	localparam int ACC_W       = 5;
	localparam int FLIGHT_W    = 8;
	localparam int CFG_W       = 8;
	localparam logic [ACC_W-1:0] ACCEPT_SAT = 5'd31;

	// Register indexes of the configuration port.
	localparam logic REG_MAX_GROUP_SIZE = 1'b0;
	localparam logic REG_MAX_IN_FLIGHT  = 1'b1;

	typedef enum logic [1:0] {
		ACT_ENQUEUE  = 2'd0,
		ACT_DISPATCH = 2'd1,
		ACT_FINISH   = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_JOINED     = 3'd0,
		ST_NEW_GROUP  = 3'd1,
		ST_DISPATCHED = 3'd2,
		ST_NOT_READY  = 3'd3,
		ST_FINISHED   = 3'd4,
		ST_REJECTED   = 3'd5
	} status_t;

	typedef struct packed {
		action_t            action;
		logic [TAG_W-1:0]   task_tag;
		logic               has_chunk;
		logic [KEY_W-1:0]   chunk_id;
		logic               keep_in_group;
	} in_item_t;

	typedef struct packed {
		status_t             status;
		logic [TAG_W-1:0]    out_tag;
		logic                out_has_chunk;
		logic [KEY_W-1:0]    out_chunk;
		logic [FLIGHT_W-1:0] in_flight_now;
		logic [COUNT_W-1:0]  groups_now;
	} out_item_t;

endpackage

// File: src/ctgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctgs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/chunk_grouping_task_scheduler.sv
// Top level of the chunk-grouping task scheduler.
// Depends on ctgs_pkg and ctgs_ram (tag store).
//
// Usage: items enter on in_item with in_valid/in_stall and results leave on
// out_item with out_valid/out_stall; every item gives exactly one result.
// The block handles one item at a time and stalls its input while busy or
// while a result is still waiting to be taken.
// Steps: a finish or refused dispatch is answered in the cycle after it is
// accepted; a dispatch reads the tag store (S_DREAD) and then updates the
// front group (S_DDONE); an enqueue scans the groups from the front until a
// match or the end of the ring is found, one slot compare per cycle.
// No new item is taken before the last result is done; the next item is
// taken at the edge where the result leaves.
// When the receiver stalls, the result is held in the output register and
// no new item is taken until it leaves.
// Reset clears the ring, all slot state, the in-flight count and sets the
// registers to max_group_size 4 and max_in_flight 8. The tag store is not
// cleared; only filled positions are ever read.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module chunk_grouping_task_scheduler
	import ctgs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DREAD = 4'b0100,
		S_DDONE = 4'b1000
	} state_t;

	state_t               state_q;
	in_item_t             item_q;
	logic [ACC_W-1:0]     max_group_size_q;
	logic [FLIGHT_W-1:0]  max_in_flight_q;
	logic [SLOT_W-1:0]    head_q;
	logic [COUNT_W-1:0]   count_q;
	logic [COUNT_W-1:0]   scan_q;
	logic [FLIGHT_W-1:0]  flight_q;
	logic                 slot_keyed_q    [MAX_GROUPS];
	logic [KEY_W-1:0]     slot_key_q      [MAX_GROUPS];
	logic [ACC_W-1:0]     slot_accepted_q [MAX_GROUPS];
	logic [POS_W-1:0]     slot_rp_q       [MAX_GROUPS];
	logic [FILL_W-1:0]    slot_fill_q     [MAX_GROUPS];
	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 in_acc, out_acc;
	logic [SLOT_W-1:0]    sidx;
	logic                 slot_match, scan_end;
	logic [KEY_W-1:0]     new_key;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
	logic [TAG_W-1:0]     ram_rdata;
	logic [POS_W-1:0]     push_pos;
	logic                 can_dispatch;
	out_item_t            idle_res;
	logic                 res_done;

	assign out_acc   = out_valid_q && !out_stall;
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && !out_acc);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign can_dispatch = (count_q != '0) && (flight_q < max_in_flight_q);

	// Slot under the scan, or the head slot during a dispatch.
	always_comb begin
		if (state_q == S_SCAN) begin
			sidx = head_q + scan_q[SLOT_W-1:0];
		end else begin
			sidx = head_q;
		end
	end

	// The shared compare unit: one slot is checked per cycle.
	assign new_key    = item_q.has_chunk ? item_q.chunk_id : '0;
	assign scan_end   = (scan_q == count_q);
	assign slot_match = (slot_keyed_q[sidx] == item_q.has_chunk)
		&& (!item_q.has_chunk || slot_key_q[sidx] == item_q.chunk_id)
		&& (item_q.keep_in_group || slot_accepted_q[sidx] < max_group_size_q);
	assign push_pos   = slot_rp_q[sidx] + slot_fill_q[sidx][POS_W-1:0];

	// Result of an item that is answered straight from the idle state.
	always_comb begin
		idle_res               = '0;
		idle_res.status        = ST_NOT_READY;
		idle_res.in_flight_now = flight_q;
		idle_res.groups_now    = count_q;
		if (in_item.action == ACT_FINISH) begin
			idle_res.status = ST_FINISHED;
			if (flight_q != '0) begin
				idle_res.in_flight_now = flight_q - 1'b1;
			end
		end
	end

	// A result is complete in this cycle.
	always_comb begin
		unique case (state_q)
			S_IDLE:  res_done = in_acc && (in_item.action != ACT_ENQUEUE)
				&& !(in_item.action == ACT_DISPATCH && can_dispatch);
			S_SCAN:  res_done = scan_end || slot_match;
			S_DREAD: res_done = 1'b0;
			S_DDONE: res_done = 1'b1;
			default: res_done = 1'b0;
		endcase
	end

	// Tag store port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {sidx, push_pos};
		ram_raddr = {head_q, slot_rp_q[head_q]};
		if (state_q == S_SCAN) begin
			if (scan_end) begin
				ram_we    = (count_q < COUNT_W'(MAX_GROUPS));
				ram_waddr = {head_q + count_q[SLOT_W-1:0], {POS_W{1'b0}}};
			end else if (slot_match) begin
				ram_we = (slot_fill_q[sidx] < FILL_W'(GROUP_DEPTH));
			end
		end
	end

	ctgs_ram #(
		.WIDTH(TAG_W),
		.DEPTH(STORE_DEPTH)
	) u_tag_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(item_q.task_tag),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_group_size_q <= ACC_W'(4);
			max_in_flight_q  <= FLIGHT_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_GROUP_SIZE: max_group_size_q <= cfg_data[ACC_W-1:0];
				REG_MAX_IN_FLIGHT:  max_in_flight_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Output valid: set when a result completes, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_done) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			scan_q      <= '0;
			flight_q    <= '0;
			for (int i = 0; i < MAX_GROUPS; i++) begin
				slot_keyed_q[i]    <= 1'b0;
				slot_key_q[i]      <= '0;
				slot_accepted_q[i] <= '0;
				slot_rp_q[i]       <= '0;
				slot_fill_q[i]     <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						item_q <= in_item;
						scan_q <= '0;
						out_q  <= idle_res;
						unique case (in_item.action)
							ACT_ENQUEUE: state_q <= S_SCAN;
							ACT_DISPATCH: begin
								if (can_dispatch) begin
									state_q <= S_DREAD;
								end
							end
							ACT_FINISH: begin
								if (flight_q != '0) begin
									flight_q <= flight_q - 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						// No group qualifies: open one at the back, or reject the task if the ring is full.
						if (count_q < COUNT_W'(MAX_GROUPS)) begin
							slot_keyed_q[ram_waddr[ADDR_W-1:POS_W]]    <= item_q.has_chunk;
							slot_key_q[ram_waddr[ADDR_W-1:POS_W]]      <= new_key;
							slot_accepted_q[ram_waddr[ADDR_W-1:POS_W]] <= ACC_W'(1);
							slot_rp_q[ram_waddr[ADDR_W-1:POS_W]]       <= '0;
							slot_fill_q[ram_waddr[ADDR_W-1:POS_W]]     <= FILL_W'(1);
							count_q <= count_q + 1'b1;
							out_q.groups_now <= count_q + 1'b1;
							out_q.status     <= ST_NEW_GROUP;
						end else begin
							out_q.status <= ST_REJECTED;
						end
						state_q     <= S_IDLE;
					end else if (slot_match) begin
						// First qualifying group takes the task or rejects it.
						if (ram_we) begin
							slot_fill_q[sidx] <= slot_fill_q[sidx] + 1'b1;
							if (slot_accepted_q[sidx] < ACCEPT_SAT) begin
								slot_accepted_q[sidx] <= slot_accepted_q[sidx] + 1'b1;
							end
							out_q.status <= ST_JOINED;
						end else begin
							out_q.status <= ST_REJECTED;
						end
						state_q     <= S_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_DREAD: begin
					state_q <= S_DDONE;
				end
				S_DDONE: begin
					// Pop the front task; drop the group once it is empty.
					slot_rp_q[head_q] <= slot_rp_q[head_q] + 1'b1;
					if (slot_fill_q[head_q] != '0) begin
						slot_fill_q[head_q] <= slot_fill_q[head_q] - 1'b1;
					end
					if (slot_fill_q[head_q] <= FILL_W'(1)) begin
						head_q  <= head_q + 1'b1;
						count_q <= count_q - 1'b1;
						out_q.groups_now <= count_q - 1'b1;
					end
					flight_q <= flight_q + 1'b1;
					out_q.in_flight_now <= flight_q + 1'b1;
					out_q.status        <= ST_DISPATCHED;
					out_q.out_tag       <= ram_rdata;
					out_q.out_has_chunk <= slot_keyed_q[head_q];
					out_q.out_chunk     <= slot_key_q[head_q];
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The ring never holds more groups than it has slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_GROUPS))
		else $error("ring count above capacity");

	// Every queued group holds at least one task.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (slot_fill_q[head_q] != '0))
		else $error("front group is empty");

	// A dispatch reaches the tag store only when a group is queued.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DREAD) |-> (count_q != '0))
		else $error("dispatch with no groups");

	// An accepted item never overwrites a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (!out_valid_q || !out_stall))
		else $error("item accepted over a pending result");

endmodule
